// ----- rtl/blg_pkg.sv -----
// Shared types and codes for the line pixel generator.
`timescale 1ns / 1ps
`default_nettype none
package blg_pkg;

    localparam int COL_W  = 9;
    localparam int ROW_W  = 8;
    localparam int DIST_W = 9;
    localparam int ERR_W  = 10;
    localparam int CLR_W  = 8;
    localparam int ADDR_W = 16;

    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [ERR_W-1:0]  err_t;
    typedef logic [CLR_W-1:0]  color_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    // step direction: hold, +1, -1
    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_INC  = 2'd1,
        DIR_DEC  = 2'd3
    } dir_t;

    // pixel handed from the step stage to the address stage
    typedef struct packed {
        logic   pixel_valid;
        col_t   pixel_x;
        row_t   pixel_y;
        color_t pixel_color;
        logic   target_buffer;
        logic   last_pixel;
    } pix_t;

endpackage
`default_nettype wire

// ----- rtl/blg_cmd_if.sv -----
// Command channel: valid/ready handshake with line endpoints and color.
`timescale 1ns / 1ps
`default_nettype none
interface blg_cmd_if;
    import blg_pkg::*;

    logic   valid;
    logic   ready;
    cmd_t   command;
    col_t   x_start;
    row_t   y_start;
    col_t   x_end;
    row_t   y_end;
    color_t line_color;

    modport source (
        output valid, command, x_start, y_start, x_end, y_end, line_color,
        input  ready
    );

    modport sink (
        input  valid, command, x_start, y_start, x_end, y_end, line_color,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/blg_pix_if.sv -----
// Pixel channel: valid/ready handshake with one pixel word.
`timescale 1ns / 1ps
`default_nettype none
interface blg_pix_if;
    import blg_pkg::*;

    logic   valid;
    logic   ready;
    logic   pixel_valid;
    col_t   pixel_x;
    row_t   pixel_y;
    addr_t  pixel_address;
    color_t pixel_color;
    logic   target_buffer;
    logic   last_pixel;

    modport source (
        output valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_color,
               target_buffer, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_color,
               target_buffer, last_pixel,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/blg_step.sv -----
// Line state, loaded by a start word, and one Bresenham step per accepted advance word.
`timescale 1ns / 1ps
`default_nettype none
module blg_step (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic            drain,
    input  wire blg_pkg::cmd_t   command,
    input  wire blg_pkg::col_t   x_start,
    input  wire blg_pkg::row_t   y_start,
    input  wire blg_pkg::col_t   x_end,
    input  wire blg_pkg::row_t   y_end,
    input  wire blg_pkg::color_t line_color,
    input  wire logic            back_buffer_enable,
    output logic                 pix_valid,
    output blg_pkg::pix_t        pix
);
    import blg_pkg::*;

    logic   busy_reg,      busy_next;
    col_t   cur_col_reg,   cur_col_next;
    row_t   cur_row_reg,   cur_row_next;
    dist_t  abs_dx_reg,    abs_dx_next;
    dist_t  abs_dy_reg,    abs_dy_next;
    dir_t   dir_x_reg,     dir_x_next;
    dir_t   dir_y_reg,     dir_y_next;
    logic   x_major_reg,   x_major_next;
    err_t   err_acc_reg,   err_acc_next;
    dist_t  steps_reg,     steps_next;
    color_t color_reg,     color_next;
    pix_t   pix_reg,       pix_next;
    logic   pix_valid_reg;

    dist_t start_dx, start_dy, start_major, step_minor, step_major;
    err_t  err_sum;
    logic  start_xmaj;

    function automatic col_t step_col(input col_t v, input dir_t d);
        case (d)
            DIR_INC: step_col = v + 1'b1;
            DIR_DEC: step_col = v - 1'b1;
            default: step_col = v;
        endcase
    endfunction

    function automatic row_t step_row(input row_t v, input dir_t d);
        case (d)
            DIR_INC: step_row = v + 1'b1;
            DIR_DEC: step_row = v - 1'b1;
            default: step_row = v;
        endcase
    endfunction

    always_comb
    begin
        busy_next    = busy_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        abs_dx_next  = abs_dx_reg;
        abs_dy_next  = abs_dy_reg;
        dir_x_next   = dir_x_reg;
        dir_y_next   = dir_y_reg;
        x_major_next = x_major_reg;
        err_acc_next = err_acc_reg;
        steps_next   = steps_reg;
        color_next   = color_reg;
        pix_next     = '0;

        // start path
        if (x_end >= x_start)
        begin
            start_dx   = x_end - x_start;
        end
        else
        begin
            start_dx   = x_start - x_end;
        end
        if (y_end >= y_start)
        begin
            start_dy   = DIST_W'(y_end - y_start);
        end
        else
        begin
            start_dy   = DIST_W'(y_start - y_end);
        end
        start_xmaj  = (start_dx >= start_dy);
        start_major = start_xmaj ? start_dx : start_dy;

        // advance path
        step_minor = x_major_reg ? abs_dy_reg : abs_dx_reg;
        step_major = x_major_reg ? abs_dx_reg : abs_dy_reg;
        err_sum    = err_acc_reg + ERR_W'(step_minor);

        if (command == CMD_START)
        begin
            color_next   = line_color;
            cur_col_next = x_start;
            cur_row_next = y_start;
            abs_dx_next  = start_dx;
            abs_dy_next  = start_dy;
            if (x_end > x_start)
                dir_x_next = DIR_INC;
            else if (x_end == x_start)
                dir_x_next = DIR_HOLD;
            else
                dir_x_next = DIR_DEC;
            if (y_end > y_start)
                dir_y_next = DIR_INC;
            else if (y_end == y_start)
                dir_y_next = DIR_HOLD;
            else
                dir_y_next = DIR_DEC;
            x_major_next = start_xmaj;
            err_acc_next = ERR_W'(start_major >> 1);
            steps_next   = start_major;
            busy_next    = (start_major != '0);
            pix_next.pixel_valid   = 1'b1;
            pix_next.pixel_x       = x_start;
            pix_next.pixel_y       = y_start;
            pix_next.pixel_color   = line_color;
            pix_next.target_buffer = back_buffer_enable;
            pix_next.last_pixel    = (start_major == '0);
        end
        else if (busy_reg)
        begin
            err_acc_next = err_sum;
            if (err_sum >= ERR_W'(step_major))
            begin
                err_acc_next = err_sum - ERR_W'(step_major);
                if (x_major_reg)
                    cur_row_next = step_row(cur_row_reg, dir_y_reg);
                else
                    cur_col_next = step_col(cur_col_reg, dir_x_reg);
            end
            if (x_major_reg)
                cur_col_next = step_col(cur_col_reg, dir_x_reg);
            else
                cur_row_next = step_row(cur_row_reg, dir_y_reg);
            steps_next = steps_reg - 1'b1;
            busy_next  = (steps_next != '0);
            pix_next.pixel_valid   = 1'b1;
            pix_next.pixel_x       = cur_col_next;
            pix_next.pixel_y       = cur_row_next;
            pix_next.pixel_color   = color_reg;
            pix_next.target_buffer = back_buffer_enable;
            pix_next.last_pixel    = (steps_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            abs_dx_reg    <= '0;
            abs_dy_reg    <= '0;
            dir_x_reg     <= DIR_HOLD;
            dir_y_reg     <= DIR_HOLD;
            x_major_reg   <= 1'b0;
            err_acc_reg   <= '0;
            steps_reg     <= '0;
            color_reg     <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg    <= busy_next;
                cur_col_reg <= cur_col_next;
                cur_row_reg <= cur_row_next;
                abs_dx_reg  <= abs_dx_next;
                abs_dy_reg  <= abs_dy_next;
                dir_x_reg   <= dir_x_next;
                dir_y_reg   <= dir_y_next;
                x_major_reg <= x_major_next;
                err_acc_reg <= err_acc_next;
                steps_reg   <= steps_next;
                color_reg   <= color_next;
            end
            if (accept)
                pix_valid_reg <= 1'b1;
            else if (drain)
                pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pix_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule
`default_nettype wire

// ----- rtl/blg_addr.sv -----
// Linear address stage and output word register.
`timescale 1ns / 1ps
`default_nettype none
module blg_addr #(
    parameter int WIDTH = 320
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire blg_pkg::pix_t pix,
    blg_pix_if.source          out
);
    import blg_pkg::*;

    localparam addr_t ROW_PITCH = ADDR_W'(WIDTH);

    logic  valid_reg;
    pix_t  pix_reg;
    addr_t addr_reg, addr_next;

    // address is taken modulo 2^16, so a 16-bit product suffices
    always_comb
    begin
        if (pix.pixel_valid)
            addr_next = ADDR_W'(pix.pixel_y) * ROW_PITCH + ADDR_W'(pix.pixel_x);
        else
            addr_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (out.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg  <= pix;
            addr_reg <= addr_next;
        end
    end

    assign out.valid         = valid_reg;
    assign out.pixel_valid   = pix_reg.pixel_valid;
    assign out.pixel_x       = pix_reg.pixel_x;
    assign out.pixel_y       = pix_reg.pixel_y;
    assign out.pixel_address = addr_reg;
    assign out.pixel_color   = pix_reg.pixel_color;
    assign out.target_buffer = pix_reg.target_buffer;
    assign out.last_pixel    = pix_reg.last_pixel;

endmodule
`default_nettype wire

// ----- rtl/bresenham_line_pixel_generator.sv -----
// Bresenham line pixel generator, top level.
//
// cmd carries one command word per handshake: start (load endpoints and
// color, emit the first pixel) or advance (emit the next pixel). Every
// command word yields exactly one pixel word on pixel; an advance with no
// line in progress yields a word with pixel_valid and all fields zero.
// cfg_we/cfg_wdata write back_buffer_enable, copied into each pixel as
// target_buffer; write it only while no words are in flight.
// A command word is registered first in the step stage and then in the
// address stage, whose register drives pixel.
// One word per cycle while pixel does not stall; the step stage (one add,
// compare and subtract on the error term) updates line state on every
// accepted word, and the row*WIDTH product sits in the following stage.
// When pixel stalls, both stages hold and cmd.ready drops once both are
// full; no word is lost or repeated.
// Reset clears the line state, the register and both stage valids.
`timescale 1ns / 1ps
`default_nettype none
module bresenham_line_pixel_generator #(
    parameter int WIDTH = 320
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    blg_cmd_if.sink   cmd,
    blg_pix_if.source pixel
);
    import blg_pkg::*;

    logic back_buffer_enable_reg;
    logic accept;
    logic s1_valid;
    logic s2_take;
    pix_t s1_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            back_buffer_enable_reg <= 1'b0;
        else if (cfg_we)
            back_buffer_enable_reg <= cfg_wdata;
    end

    assign s2_take   = s1_valid && (!pixel.valid || pixel.ready);
    assign cmd.ready = !s1_valid || s2_take;
    assign accept    = cmd.valid && cmd.ready;

    blg_step u_step (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .drain              (s2_take),
        .command            (cmd.command),
        .x_start            (cmd.x_start),
        .y_start            (cmd.y_start),
        .x_end              (cmd.x_end),
        .y_end              (cmd.y_end),
        .line_color         (cmd.line_color),
        .back_buffer_enable (back_buffer_enable_reg),
        .pix_valid          (s1_valid),
        .pix                (s1_pix)
    );

    blg_addr #(
        .WIDTH (WIDTH)
    ) u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (s2_take),
        .pix   (s1_pix),
        .out   (pixel)
    );

    // idle advance word carries all-zero fields
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && !pixel.pixel_valid |->
            pixel.pixel_x == '0 && pixel.pixel_y == '0 && pixel.pixel_address == '0
            && pixel.pixel_color == '0 && !pixel.last_pixel && !pixel.target_buffer)
        else $error("idle word has nonzero fields");

    // address matches coordinates
    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid |-> pixel.pixel_address ==
            ADDR_W'(ADDR_W'(pixel.pixel_y) * ADDR_W'(WIDTH) + ADDR_W'(pixel.pixel_x)))
        else $error("pixel address mismatch");

    // a single-point start is its own last pixel
    a_point: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == CMD_START && cmd.x_start == cmd.x_end
            && cmd.y_start == cmd.y_end |=> s1_valid && s1_pix.last_pixel)
        else $error("single-point line not flagged last");

    // an empty step stage never blocks the command channel
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid |-> cmd.ready)
        else $error("command stalled with empty step stage");

endmodule
`default_nettype wire
